FILE: rtl/sma_pkg.sv
// Shared constants and control types for the windowed moving average.
// No dependencies; sma_window and windowed_moving_average refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

  // Default sizing of the filter
  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Window length after reset
  localparam int LEN_RESET = 8;

  // Step strobes from the sequencer to the window store
  typedef struct packed {
    logic rd;   // latch the sample, read the slot at the write position
    logic add;  // add the new sample into the running sum
    logic sub;  // retire the oldest sample or grow the fill, store the new one
  } win_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sma_sample_if.sv
// Input channel of the moving average: one signed sample per transaction.
// Standalone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sma_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/sma_result_if.sv
// Result channel of the moving average: average and fill level per transaction.
// Standalone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sma_result_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FILL_WIDTH   = 7
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;
  logic        [FILL_WIDTH-1:0]   fill_level;

  modport source (output valid, output average, output fill_level, input ready);
  modport sink   (input valid, input average, input fill_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/sma_cfg_if.sv
// Configuration write channel: carries the window length register.
// Standalone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sma_cfg_if #(
  parameter int LEN_WIDTH = 7
);
  logic                 valid;
  logic                 ready;
  logic [LEN_WIDTH-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/sma_window.sv
// Sample ring memory, write pointer, fill count, running sum and window length.
// Depends on sma_pkg (win_ctl_t, LEN_RESET).
`timescale 1ns / 1ps
`default_nettype none

module sma_window #(
  parameter int WINDOW_MAX   = sma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = sma_pkg::SAMPLE_WIDTH_DEF,
  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1),
  localparam int SUM_W  = SAMPLE_WIDTH + ADDR_W
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire        [LEN_W-1:0]         cfg_len,
  input  wire sma_pkg::win_ctl_t         ctl,
  input  wire signed [SAMPLE_WIDTH-1:0]  sample_in,
  output logic signed [SUM_W-1:0]        sum,
  output logic       [LEN_W-1:0]         held
);

  localparam int LEN_RST_I =
    (sma_pkg::LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : sma_pkg::LEN_RESET;
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(LEN_RST_I);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic signed [SAMPLE_WIDTH-1:0] old_smp;
  logic        [ADDR_W-1:0]       write_position;
  logic        [LEN_W-1:0]        held_count;
  logic        [LEN_W-1:0]        len;
  logic        [LEN_W-1:0]        len_next;
  logic        [LEN_W-1:0]        pos_inc;
  logic signed [SUM_W-1:0]        running_sum;
  logic                           full;

  // Zero means a single sample, anything above the store depth saturates
  always_comb begin
    if (cfg_len == '0) begin
      len_next = LEN_ONE;
    end else if (cfg_len > LEN_MAX) begin
      len_next = LEN_MAX;
    end else begin
      len_next = cfg_len;
    end
  end

  assign full    = (held_count == len);
  assign pos_inc = LEN_W'(write_position) + LEN_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      len            <= LEN_RST;
      write_position <= '0;
      held_count     <= '0;
      running_sum    <= '0;
    end else if (cfg_we) begin
      len            <= len_next;
      write_position <= '0;
      held_count     <= '0;
      running_sum    <= '0;
    end else if (ctl.add) begin
      running_sum <= running_sum + SUM_W'(smp);
    end else if (ctl.sub) begin
      if (full) begin
        running_sum <= running_sum - SUM_W'(old_smp);
      end else begin
        held_count <= held_count + LEN_ONE;
      end
      write_position <= (pos_inc == len) ? '0 : pos_inc[ADDR_W-1:0];
    end
  end

  // Ring memory: one read port, one write port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      smp     <= sample_in;
      old_smp <= ring[write_position];
    end
    if (ctl.sub) begin
      ring[write_position] <= smp;
    end
  end

  assign sum  = running_sum;
  assign held = held_count;

endmodule

`default_nettype wire

FILE: rtl/sma_div.sv
// Bit-serial restoring divider: one quotient bit per cycle through a shift register.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sma_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire [DIVIDEND_W-1:0]  dividend,
  input  wire [DIVISOR_W-1:0]   divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // Bring down the next dividend bit and try a subtract
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_LOAD;
    end else if (busy) begin
      cnt <= cnt - CNT_ONE;
      if (cnt == CNT_ONE) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = busy && (cnt == CNT_ONE);
  assign quotient = quo;

endmodule

`default_nettype wire

FILE: rtl/windowed_moving_average.sv
// Top level of the windowed moving average (boxcar filter) over signed samples.
// Depends on sma_pkg, sma_sample_if, sma_result_if, sma_cfg_if, sma_window, sma_div.
//
//   channel   role    payload                  transaction moves
//   samples   sink    sample                   one new sample
//   results   source  average, fill_level      mean of held samples and their count
//   cfg       sink    window_length            new window length, empties the window
//
// An accepted sample passes through ADD, SUB, START and DIV, and its result is loaded
// into the output register from HOLD; the serial divider produces one quotient bit per
// cycle, one for each bit of the running sum. One sample is in flight at a time; the
// next is taken once the result is loaded.
// Reset is synchronous: the window is empty and its length is 8 (capped at WINDOW_MAX) afterwards.
// A stalled result holds in the output register; the block then waits in HOLD.
`timescale 1ns / 1ps
`default_nettype none

module windowed_moving_average #(
  parameter int WINDOW_MAX   = sma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = sma_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  sma_sample_if.sink   samples,
  sma_result_if.source results,
  sma_cfg_if.sink      cfg
);

  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + ADDR_W;

  // One-hot sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,  // wait for a sample
    ST_ADD   = 6'b000010,  // old sample read out, add the new one
    ST_SUB   = 6'b000100,  // drop the oldest sample, store the new one
    ST_START = 6'b001000,  // load the divider with the sum magnitude
    ST_DIV   = 6'b010000,  // one quotient bit per cycle
    ST_HOLD  = 6'b100000   // wait for the output register to free up
  } state_t;

  state_t                  state;
  state_t                  state_next;
  sma_pkg::win_ctl_t       ctl;
  logic                    accept;
  logic                    out_free;
  logic                    cfg_we;
  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] sum_mag;
  logic        [LEN_W-1:0] held;
  logic                    neg;
  logic                    div_start;
  logic                    div_done;
  logic        [SUM_W-1:0] quotient;
  logic [SAMPLE_WIDTH-1:0] q_lo;
  logic                    out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_avg;
  logic        [LEN_W-1:0] out_fill;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !out_valid || results.ready;
  assign cfg_we   = cfg.valid && cfg.ready;

  // Take a sample only between items; configuration is taken only then too
  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = (state == ST_IDLE);

  assign ctl.rd    = accept;
  assign ctl.add   = (state == ST_ADD);
  assign ctl.sub   = (state == ST_SUB);
  assign div_start = (state == ST_START);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_ADD;
      ST_ADD:   state_next = ST_SUB;
      ST_SUB:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  sma_window #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_len   (cfg.window_length),
    .ctl       (ctl),
    .sample_in (samples.sample),
    .sum       (sum),
    .held      (held)
  );

  // Divide magnitudes so the quotient truncates toward zero; restore the sign after
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg <= sum[SUM_W-1];
    end
  end

  sma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (held),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_lo = quotient[SAMPLE_WIDTH-1:0];

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && out_free) begin
      out_avg  <= neg ? SAMPLE_WIDTH'(-q_lo) : q_lo;
      out_fill <= held;
    end
  end

  assign results.valid      = out_valid;
  assign results.average    = out_avg;
  assign results.fill_level = out_fill;

`ifndef NO_ASSERTIONS
  a_state_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state is not one-hot");

  a_accept_to_add : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_ADD))
    else $error("accepted sample did not start the sum update");

  a_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_fill_range : assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.fill_level != '0) &&
                      (results.fill_level <= LEN_W'(WINDOW_MAX)))
    else $error("result fill level out of range");

  a_hold_loads : assert property (@(posedge clk) disable iff (rst)
    ((state == ST_HOLD) && out_free) |=> (results.valid && (state == ST_IDLE)))
    else $error("finished result was not loaded into the output register");
`endif

endmodule

`default_nettype wire
